// ----- hdl/srtp_stream_session_table_defines.svh -----
// Assertion macros for the checker file of the session table.
`ifndef SRTP_STREAM_SESSION_TABLE_DEFINES_SVH
`define SRTP_STREAM_SESSION_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/srtp_pkg.sv -----
package srtp_pkg;

   localparam logic [2:0] FUNC_APPEND   = 3'd0;
   localparam logic [2:0] FUNC_REPLACE  = 3'd1;
   localparam logic [2:0] FUNC_SET_SSRC = 3'd2;
   localparam logic [2:0] FUNC_SET_ROC  = 3'd3;
   localparam logic [2:0] FUNC_LOOKUP   = 3'd4;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] ssrc;
      logic [31:0] roc;
      logic [7:0]  policy;
      logic [7:0]  cs_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_index;
      logic [7:0]  found_policy;
      logic [31:0] found_roc;
      logic [7:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ssrc;
      logic [31:0] roc;
      logic [7:0]  policy;
   } entry_type;

   typedef struct packed {
      logic wr_ssrc;
      logic wr_roc;
      logic wr_policy;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- hdl/srtp_stream_session_table.sv -----
// Session table with a command interface. An item is taken when start is
// high and busy is low; its single result shows on rsp_data for one cycle
// with rsp_strobe, and the receiver cannot stall it. Append, replace and
// the set operations act in the EXEC state, and their result is then
// registered to rsp_data. A lookup compares one stored entry per cycle
// through the table memory's single read port, so it reads up to
// entry_count entries (16 for a full table) before its result. A new item
// may be started in the cycle its predecessor's result is shown.
module srtp_stream_session_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  srtp_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output srtp_pkg::rsp_type rsp_data
);
   import srtp_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic             accept;
   logic             done;
   req_type          req_ff;
   rsp_type          rsp_in;
   rsp_type          rsp_ff;
   logic             strobe_ff;
   mem_ctl_type      mem_ctl;
   logic [IDX_W-1:0] waddr;
   logic [IDX_W-1:0] raddr;
   entry_type        wdata;
   entry_type        rdata;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   srtp_seq #(
      .DEPTH (TABLE_DEPTH),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_ff),
      .rdata   (rdata),
      .busy    (busy),
      .done    (done),
      .rsp     (rsp_in),
      .mem_ctl (mem_ctl),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr   (raddr)
   );

   srtp_mem #(
      .IDX_W (IDX_W),
      .DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= done;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hdl/srtp_mem.sv -----
module srtp_mem #(
   parameter int IDX_W = 4,
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  srtp_pkg::mem_ctl_type ctl,
   input  logic [IDX_W-1:0]      waddr,
   input  srtp_pkg::entry_type   wdata,
   input  logic [IDX_W-1:0]      raddr,
   output srtp_pkg::entry_type   rdata
);
   import srtp_pkg::*;

   logic [31:0] ssrc_mem   [DEPTH];
   logic [31:0] roc_mem    [DEPTH];
   logic [7:0]  policy_mem [DEPTH];
   entry_type   rdata_ff;

   // Each field has its own write enable so that single-field updates
   // leave the other fields of the entry alone.
   always_ff @(posedge clock) begin
      if (ctl.wr_ssrc) begin
         ssrc_mem[waddr] <= wdata.ssrc;
      end
      if (ctl.wr_roc) begin
         roc_mem[waddr] <= wdata.roc;
      end
      if (ctl.wr_policy) begin
         policy_mem[waddr] <= wdata.policy;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff.ssrc   <= ssrc_mem[raddr];
         rdata_ff.roc    <= roc_mem[raddr];
         rdata_ff.policy <= policy_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/srtp_seq.sv -----
module srtp_seq #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5,
   parameter int IDX_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  srtp_pkg::req_type     req,
   input  srtp_pkg::entry_type   rdata,
   output logic                  busy,
   output logic                  done,
   output srtp_pkg::rsp_type     rsp,
   output srtp_pkg::mem_ctl_type mem_ctl,
   output logic [IDX_W-1:0]      waddr,
   output srtp_pkg::entry_type   wdata,
   output logic [IDX_W-1:0]      raddr
);
   import srtp_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             vld_ff, vld_in;
   logic             scan_rd;
   logic             scan_hit;
   logic             id_ok;
   logic             is_lookup;

   // The scan reads one entry per cycle; the compare sees the entry read
   // in the previous cycle, whose one-based number is the current pointer.
   assign scan_rd   = (ptr_ff < count_ff);
   assign scan_hit  = vld_ff && (rdata.ssrc == req.ssrc);
   assign id_ok     = (req.cs_id != 8'd0) && (req.cs_id <= 8'(count_ff));
   assign is_lookup = (req.func == FUNC_LOOKUP);

   assign wdata.ssrc   = req.ssrc;
   assign wdata.roc    = req.roc;
   assign wdata.policy = req.policy;
   assign raddr        = IDX_W'(ptr_ff);
   assign busy         = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = is_lookup ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_hit || !scan_rd) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      vld_in           = 1'b0;
      done             = 1'b0;
      mem_ctl          = '0;
      waddr            = IDX_W'(count_ff);
      rsp.status       = STATUS_DONE;
      rsp.found_index  = 8'd0;
      rsp.found_policy = 8'd0;
      rsp.found_roc    = 32'd0;
      unique case (state_ff)
         ST_IDLE: begin
            ptr_in = '0;
         end
         ST_EXEC: begin
            unique case (req.func) inside
               FUNC_APPEND: begin
                  done = 1'b1;
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp.status = STATUS_FULL;
                  end else begin
                     mem_ctl.wr_ssrc   = 1'b1;
                     mem_ctl.wr_roc    = 1'b1;
                     mem_ctl.wr_policy = 1'b1;
                     count_in          = count_ff + CNT_W'(1);
                  end
               end
               FUNC_REPLACE, FUNC_SET_SSRC, FUNC_SET_ROC: begin
                  done  = 1'b1;
                  waddr = IDX_W'(req.cs_id - 8'd1);
                  if (id_ok) begin
                     mem_ctl.wr_ssrc   = (req.func != FUNC_SET_ROC);
                     mem_ctl.wr_roc    = (req.func != FUNC_SET_SSRC);
                     mem_ctl.wr_policy = (req.func == FUNC_REPLACE);
                  end else begin
                     rsp.status = STATUS_BAD_ID;
                  end
               end
               FUNC_LOOKUP: begin
                  ptr_in = '0;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            mem_ctl.rd_en = scan_rd;
            vld_in        = scan_rd;
            if (scan_rd) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (scan_hit) begin
               done             = 1'b1;
               rsp.found_index  = 8'(ptr_ff);
               rsp.found_policy = rdata.policy;
               rsp.found_roc    = rdata.roc;
            end else if (!scan_rd) begin
               done = 1'b1;
            end
         end
         default: begin
            ptr_in = '0;
         end
      endcase
      rsp.entry_count = 8'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ptr_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

// ----- hdl/srtp_chk.sv -----
`include "srtp_stream_session_table_defines.svh"

module srtp_chk #(
   parameter int TABLE_DEPTH = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input srtp_pkg::rsp_type rsp_data
);
   import srtp_pkg::*;

   logic rsp_miss;
   logic cmd_taken;

   assign cmd_taken = start && !busy;
   assign rsp_miss  = (rsp_data.found_index == 8'd0) && (rsp_data.found_policy == 8'd0)
                      && (rsp_data.found_roc == 32'd0);

   `SRTP_ASSERT_NEXT(a_busy_after_take, clock, reset, cmd_taken, busy, "not busy after transfer")
   `SRTP_ASSERT_SAME(a_idle_at_result, clock, reset, rsp_strobe, !busy, "busy during result")
   `SRTP_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "strobe held twice")
   `SRTP_ASSERT_SAME(a_fail_no_hit, clock, reset, rsp_strobe && (rsp_data.status != STATUS_DONE), rsp_miss, "lookup fields set on failed item")
   `SRTP_ASSERT_SAME(a_count_bound, clock, reset, rsp_strobe, rsp_data.entry_count <= 8'(TABLE_DEPTH), "entry count beyond depth")

endmodule

bind srtp_stream_session_table srtp_chk #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
